// ----- rtl/core/sst_pkg.sv -----
// Shared types and constants for the sorted set table.
package sst_pkg;

   localparam int SST_CAPACITY = 64;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   // Per-cycle control broadcast to every cell
   typedef struct packed {
      logic capture;   // latch compare flags against the incoming key
      logic ins;       // open a slot at the insert point and shift up
      logic del;       // close the slot of the matching key and shift down
   } sst_ctl_type;

endpackage

// ----- rtl/core/sst_cell.sv -----
// One table slot: holds a key, compares it with the request and shifts with its neighbors.
module sst_cell
   import sst_pkg::*;
#(
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  sst_ctl_type        ctl,
   input  logic [CNT_W-1:0]   count,
   input  logic signed [31:0] cmp_value,
   input  logic signed [31:0] ins_value,
   input  logic signed [31:0] left_key,
   input  logic               left_lt,
   input  logic signed [31:0] right_key,
   output logic signed [31:0] key,
   output logic               lt,
   output logic               eq
);

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic signed [31:0] key_ff, key_in;
   logic               lt_ff, lt_in;
   logic               eq_ff, eq_in;
   logic               occupied;

   assign occupied = (IDX < count);

   always_comb begin
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      key_in = key_ff;
      if (ctl.capture) begin
         lt_in = occupied && (key_ff < cmp_value);
         eq_in = occupied && (key_ff == cmp_value);
      end
      // Entries below the insert/remove point keep their place
      if (ctl.ins && !lt_ff) begin
         key_in = left_lt ? ins_value : left_key;
      end else if (ctl.del && !lt_ff) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key = key_ff;
   assign lt  = lt_ff;
   assign eq  = eq_ff;

endmodule

// ----- rtl/core/sorted_set_table_unit.sv -----
// Sorted set table: ascending duplicate-free key table built from a row of shift cells.
// Flow: a request is accepted only in the idle state, so a new command waits until the last one
// is done; the transfer cycle compares the key in every cell, then the update state shifts the
// cells and loads the result register (held while it is stalled).
// Reset (synchronous): clears the element count, the sequencer and the result valid.
// Key storage is not cleared; slots at or above the count are never observed.
module sorted_set_table_unit
   import sst_pkg::*;
#(
   parameter int CAPACITY = SST_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_was_present,
   output logic [6:0]         rsp_count,
   output logic               rsp_overflow
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_UPD  = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [1:0]         cmd_ff;
   logic signed [31:0] value_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_present_ff;
   logic [6:0]         rsp_size_ff;
   logic               rsp_ovf_ff;

   sst_ctl_type        ctl;
   logic               req_fire;
   logic               upd_fire;
   logic               present;
   logic               full;
   logic               is_add;
   logic               is_remove;
   logic [CNT_W+6:0]   count_ext;

   logic signed [31:0] key_chain [CAPACITY];
   logic [CAPACITY-1:0] lt_vec;
   logic [CAPACITY-1:0] eq_vec;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign upd_fire  = (state_ff == ST_UPD) && !(rsp_valid_ff && rsp_stall);

   assign present   = |eq_vec;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign is_add    = (cmd_ff == CMD_ADD);
   assign is_remove = (cmd_ff == CMD_REMOVE);

   assign ctl.capture = req_fire;
   assign ctl.ins     = upd_fire && is_add && !present && !full;
   assign ctl.del     = upd_fire && is_remove && present;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [31:0] lkey;
         logic               llt;
         logic signed [31:0] rkey;
         if (gi == 0) begin : g_first
            assign lkey = value_ff;
            assign llt  = 1'b1;
         end else begin : g_mid
            assign lkey = key_chain[gi-1];
            assign llt  = lt_vec[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign rkey = key_chain[gi];
         end else begin : g_inner
            assign rkey = key_chain[gi+1];
         end
         sst_cell #(
            .CNT_W (CNT_W),
            .INDEX (gi)
         ) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .count     (count_ff),
            .cmp_value (req_value),
            .ins_value (value_ff),
            .left_key  (lkey),
            .left_lt   (llt),
            .right_key (rkey),
            .key       (key_chain[gi]),
            .lt        (lt_vec[gi]),
            .eq        (eq_vec[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_UPD;
         ST_UPD:  if (upd_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign count_ext = {7'd0, count_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (upd_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value;
      end
      if (upd_fire) begin
         rsp_present_ff <= present;
         rsp_size_ff    <= count_ext[6:0];
         rsp_ovf_ff     <= is_add && !present && full;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_was_present = rsp_present_ff;
   assign rsp_count       = rsp_size_ff;
   assign rsp_overflow    = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> $onehot0(eq_vec))
      else $error("key matched in more than one slot");

   a_ins_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.ins |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the count");

   a_del_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctl.del |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("remove did not shrink the count");

   a_query_holds: assert property (@(posedge clock) disable iff (reset)
      (upd_fire && !is_add && !is_remove) |=> $stable(count_ff))
      else $error("query changed the count");
`endif

endmodule
